>>> rtl/sorted_free_list_allocator_defines.svh
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Shared concurrent assertion forms for the free-list allocator.
// ----------------------------------------------------------------------------
`ifndef SORTED_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SORTED_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked at each rising clock outside reset
`define SFLA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at each rising clock outside reset
`define SFLA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sfla_pkg.sv
// ----------------------------------------------------------------------------
// Free-list allocator package
// Types and fixed constants shared by the allocator and its field unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sfla_pkg;

   // Width of a byte address into the arena (covers split-block overflow)
   localparam int FA_W = 34;
   // Header field and link widths
   localparam int FIELD_W = 32;
   localparam int OFF_W = 31;
   localparam int FIELD_BYTES = 4;

   // Register indexes
   localparam logic REG_FIT_POLICY = 1'b0;
   localparam logic REG_ARENA_BYTES = 1'b1;

   // Fit policies
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   // Result status codes
   localparam logic [1:0] STS_DONE = 2'd0;
   localparam logic [1:0] STS_NOFIT = 2'd1;
   localparam logic [1:0] STS_IGNORED = 2'd2;

   // Request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE = 1'b1;

   typedef enum logic [1:0] {
      FU_READ,
      FU_WRITE,
      FU_CLEAR
   } fu_op_type;

   typedef struct packed {
      fu_op_type op;
      logic [FA_W-1:0] addr;
      logic [FIELD_W-1:0] data;
   } fu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [FIELD_W-1:0] rdata;
   } fu_sts_type;

   typedef enum logic [1:0] {
      FS_IDLE,
      FS_READ,
      FS_WRITE,
      FS_CLEAR
   } fu_state_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_WAIT,
      ST_RESP,
      ST_A_MUL,
      ST_A_SETUP,
      ST_A_LOOP,
      ST_A_SIZE,
      ST_A_NEXT,
      ST_A_TLINK,
      ST_A_SPLIT2,
      ST_A_SPLIT3,
      ST_A_SETLINK,
      ST_A_CLRLINK,
      ST_F_CHK,
      ST_F_LOOP,
      ST_F_NEXT,
      ST_F_ST,
      ST_F_TLINK,
      ST_F_NCHK,
      ST_F_NSZ,
      ST_F_NLNK,
      ST_F_NWR,
      ST_F_PCHK,
      ST_F_PSZ,
      ST_F_PLNK,
      ST_F_PWR
   } st_type;

endpackage

>>> rtl/sfla_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/sfla_field_unit.sv
// ----------------------------------------------------------------------------
// Header field unit
// Byte-serial reads and writes of header fields, and the arena clearing sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sfla_field_unit import sfla_pkg::*; #(
   parameter int ARENA_BYTES = 65536,
   parameter int HEADER_BYTES = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  fu_cmd_type cmd,
   output fu_sts_type sts
);

   localparam int AW = $clog2(ARENA_BYTES);
   localparam int HALF = HEADER_BYTES / 2;
   localparam int CW = $clog2(HALF + 1);

   fu_state_type fst_ff, fst_in;
   logic [FA_W-1:0] addr_ff, addr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [FIELD_W-1:0] wdat_ff, wdat_in;
   logic [FIELD_W-1:0] rdat_ff, rdat_in;
   logic inr_ff, inr_in;
   logic done_ff, done_in;

   logic ram_we;
   logic [7:0] ram_q;
   logic inrange;

   assign inrange = addr_ff < FA_W'(ARENA_BYTES);

   sfla_ram #(
      .WIDTH(8),
      .DEPTH(ARENA_BYTES)
   ) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(addr_ff[AW-1:0]),
      .wdata(wdat_ff[7:0]),
      .raddr(addr_ff[AW-1:0]),
      .rdata(ram_q)
   );

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fst_ff <= FS_IDLE;
         done_ff <= 1'b0;
      end else begin
         fst_ff <= fst_in;
         done_ff <= done_in;
      end
   end

   // Hold datapath
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      cnt_ff <= cnt_in;
      wdat_ff <= wdat_in;
      rdat_ff <= rdat_in;
      inr_ff <= inr_in;
   end

   // Sequence bytes
   always_comb begin
      fst_in = fst_ff;
      addr_in = addr_ff;
      cnt_in = cnt_ff;
      wdat_in = wdat_ff;
      rdat_in = rdat_ff;
      inr_in = inr_ff;
      done_in = 1'b0;
      ram_we = 1'b0;
      unique case (fst_ff)
         FS_IDLE: begin
            if (start) begin
               addr_in = cmd.addr;
               wdat_in = cmd.data;
               cnt_in = '0;
               unique case (cmd.op)
                  FU_READ: fst_in = FS_READ;
                  FU_WRITE: fst_in = FS_WRITE;
                  FU_CLEAR: begin
                     fst_in = FS_CLEAR;
                     addr_in = '0;
                  end
                  default: fst_in = FS_IDLE;
               endcase
            end
         end
         FS_READ: begin
            // Issue one byte, collect the one issued before; out of range reads zero
            if (cnt_ff < CW'(FIELD_BYTES)) begin
               inr_in = inrange;
               addr_in = addr_ff + FA_W'(1);
            end
            if (cnt_ff != '0) begin
               rdat_in = {(inr_ff ? ram_q : 8'd0), rdat_ff[FIELD_W-1:8]};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(FIELD_BYTES)) begin
               fst_in = FS_IDLE;
               done_in = 1'b1;
            end
         end
         FS_WRITE: begin
            // Write value bytes then zero fill; drop bytes beyond the arena
            ram_we = inrange;
            addr_in = addr_ff + FA_W'(1);
            wdat_in = {8'd0, wdat_ff[FIELD_W-1:8]};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(HALF - 1)) begin
               fst_in = FS_IDLE;
               done_in = 1'b1;
            end
         end
         FS_CLEAR: begin
            // Sweep the whole arena; the first bytes carry the initial size
            ram_we = 1'b1;
            addr_in = addr_ff + FA_W'(1);
            wdat_in = {8'd0, wdat_ff[FIELD_W-1:8]};
            if (addr_ff == FA_W'(ARENA_BYTES - 1)) begin
               fst_in = FS_IDLE;
               done_in = 1'b1;
            end
         end
         default: fst_in = FS_IDLE;
      endcase
   end

   assign sts.busy = (fst_ff != FS_IDLE);
   assign sts.done = done_ff;
   assign sts.rdata = rdat_ff;

endmodule

>>> rtl/sorted_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Sorted free-list allocator
// Address-ordered free list over a byte arena with first, best or worst fit.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one allocate or free word; rsp_* returns one result word per
//   request. csr_* writes fit_policy (index 0) or arena_bytes (index 1); the user
//   is to write them only while idle, which the block itself does not enforce.
//   Every header field goes through one byte-serial field unit on a single arena
//   RAM port. An allocate walks the whole free list, with setup before the walk
//   and split and relink after it. A free walks up to the target, then relinks
//   and, where blocks touch, merges.
//   One request is worked at a time; req_tready is low until it finishes.
//   Reset, and each write of arena_bytes, runs a clearing pass over the whole
//   arena RAM, during which no request is taken.
//   The result waits in an output register; a stalled receiver holds it while
//   the next request is already taken and worked, which then waits to load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_free_list_allocator_defines.svh"
module sorted_free_list_allocator import sfla_pkg::*; #(
   parameter int ARENA_BYTES = 65536,
   parameter int HEADER_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [16:0] elem_size, [33:17] elem_count, [49:34] free_offset, [50] free_valid
   input  logic [55:0] req_tdata,
   // [0] req_type
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] block_offset, [32:16] granted_bytes
   output logic [39:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [16:0] csr_data
);

   localparam int HALF = HEADER_BYTES / 2;
   localparam int WALK_LIMIT = ARENA_BYTES / HEADER_BYTES + 1;
   localparam int NW = $clog2(WALK_LIMIT + 1);
   localparam logic [FA_W-1:0] HDR_A = FA_W'(HEADER_BYTES);
   localparam logic [FA_W-1:0] HALF_A = FA_W'(HALF);
   localparam logic [FIELD_W-1:0] HDR_F = FIELD_W'(HEADER_BYTES);
   localparam logic [FIELD_W-1:0] ARENA_F = FIELD_W'(ARENA_BYTES);

   st_type state_ff, state_in, ret_ff, ret_in;
   logic [1:0] fit_ff, fit_in;
   logic [16:0] arena_ff, arena_in;
   logic pend_ff, pend_in;
   logic [OFF_W-1:0] head_ff, head_in;
   logic hv_ff, hv_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;
   logic [1:0] rsp_user_ff, rsp_user_in;

   logic [16:0] size_ff, size_in;
   logic [16:0] count_ff, count_in;
   logic [15:0] off_ff, off_in;
   logic fv_ff, fv_in;
   logic [FA_W-1:0] prod_ff, prod_in;
   logic [FA_W-1:0] rq_ff, rq_in;
   logic [OFF_W-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic cv_ff, cv_in, pv_ff, pv_in;
   logic [NW-1:0] n_ff, n_in;
   logic found_ff, found_in, tpv_ff, tpv_in;
   logic [OFF_W-1:0] tgt_ff, tgt_in, tprev_ff, tprev_in;
   logic [FIELD_W-1:0] tsize_ff, tsize_in;
   logic [FIELD_W-1:0] nx_ff, nx_in, diff_ff, diff_in, grant_ff, grant_in;
   logic [FIELD_W-1:0] repl_ff, repl_in, st_ff, st_in;
   logic [FA_W-1:0] nb_ff, nb_in;
   logic [1:0] rs_ff, rs_in;
   logic [15:0] roff_ff, roff_in;
   logic [16:0] rgrant_ff, rgrant_in;

   logic fu_start;
   fu_cmd_type fu_cmd;
   fu_sts_type fu_sts;

   logic [FIELD_W-1:0] ab_f, eff_f, s_f, diff_c, sum_c;
   logic take, arena_wr;

   sfla_field_unit #(
      .ARENA_BYTES(ARENA_BYTES),
      .HEADER_BYTES(HEADER_BYTES)
   ) u_field (
      .clock(clock),
      .reset(reset),
      .start(fu_start),
      .cmd(fu_cmd),
      .sts(fu_sts)
   );

   // Clamp the arena size
   assign ab_f = FIELD_W'(arena_ff);
   assign eff_f = (ab_f < HDR_F) ? HDR_F : ((ab_f > ARENA_F) ? ARENA_F : ab_f);
   assign s_f = fu_sts.rdata;

   assign arena_wr = csr_valid && (csr_index == REG_ARENA_BYTES);
   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && !pend_ff && !arena_wr;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   // Candidate choice for the walk
   assign take = ({2'b00, s_f} >= rq_ff) &&
                 (!found_ff || ((fit_ff == FIT_BEST) && (s_f < tsize_ff)) ||
                  ((fit_ff == FIT_WORST) && (s_f > tsize_ff)));
   assign diff_c = tsize_ff - rq_ff[FIELD_W-1:0];
   assign sum_c = st_ff + s_f + HDR_F;

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ret_ff <= ST_IDLE;
         fit_ff <= FIT_FIRST;
         arena_ff <= 17'h10000;
         pend_ff <= 1'b0;
         head_ff <= '0;
         hv_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         fit_ff <= fit_in;
         arena_ff <= arena_in;
         pend_ff <= pend_in;
         head_ff <= head_in;
         hv_ff <= hv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold datapath
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      size_ff <= size_in;
      count_ff <= count_in;
      off_ff <= off_in;
      fv_ff <= fv_in;
      prod_ff <= prod_in;
      rq_ff <= rq_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      cv_ff <= cv_in;
      pv_ff <= pv_in;
      n_ff <= n_in;
      found_ff <= found_in;
      tpv_ff <= tpv_in;
      tgt_ff <= tgt_in;
      tprev_ff <= tprev_in;
      tsize_ff <= tsize_in;
      nx_ff <= nx_in;
      diff_ff <= diff_in;
      grant_ff <= grant_in;
      repl_ff <= repl_in;
      st_ff <= st_in;
      nb_ff <= nb_in;
      rs_ff <= rs_in;
      roff_ff <= roff_in;
      rgrant_ff <= rgrant_in;
   end

   // Sequence requests through the field unit
   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      fit_in = fit_ff;
      arena_in = arena_ff;
      pend_in = pend_ff;
      head_in = head_ff;
      hv_in = hv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      size_in = size_ff;
      count_in = count_ff;
      off_in = off_ff;
      fv_in = fv_ff;
      prod_in = prod_ff;
      rq_in = rq_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      cv_in = cv_ff;
      pv_in = pv_ff;
      n_in = n_ff;
      found_in = found_ff;
      tpv_in = tpv_ff;
      tgt_in = tgt_ff;
      tprev_in = tprev_ff;
      tsize_in = tsize_ff;
      nx_in = nx_ff;
      diff_in = diff_ff;
      grant_in = grant_ff;
      repl_in = repl_ff;
      st_in = st_ff;
      nb_in = nb_ff;
      rs_in = rs_ff;
      roff_in = roff_ff;
      rgrant_in = rgrant_ff;
      fu_start = 1'b0;
      fu_cmd.op = FU_READ;
      fu_cmd.addr = '0;
      fu_cmd.data = '0;

      // Take register writes
      if (csr_valid) begin
         unique case (csr_index)
            REG_FIT_POLICY: fit_in = csr_data[1:0];
            REG_ARENA_BYTES: begin
               arena_in = csr_data;
               pend_in = 1'b1;
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_INIT: begin
            fu_start = 1'b1;
            fu_cmd.op = FU_CLEAR;
            fu_cmd.data = eff_f - HDR_F;
            head_in = '0;
            hv_in = 1'b1;
            if (!arena_wr) begin
               pend_in = 1'b0;
            end
            ret_in = ST_IDLE;
            state_in = ST_WAIT;
         end
         ST_IDLE: begin
            if (pend_ff) begin
               state_in = ST_INIT;
            end else if (req_tvalid && req_tready) begin
               size_in = req_tdata[16:0];
               count_in = req_tdata[33:17];
               off_in = req_tdata[49:34];
               fv_in = req_tdata[50];
               state_in = (req_tuser[0] == REQ_FREE) ? ST_F_CHK : ST_A_MUL;
            end
         end
         ST_WAIT: begin
            if (fu_sts.done) begin
               state_in = ret_ff;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in = rs_ff;
               rsp_data_in = {7'd0, rgrant_ff, roff_ff};
               state_in = ST_IDLE;
            end
         end

         // ---------------- allocate ----------------
         ST_A_MUL: begin
            prod_in = FA_W'(size_ff) * FA_W'(count_ff);
            cur_in = head_ff;
            cv_in = hv_ff;
            pv_in = 1'b0;
            prev_in = '0;
            found_in = 1'b0;
            n_in = '0;
            rs_in = STS_NOFIT;
            roff_in = '0;
            rgrant_in = '0;
            state_in = ST_A_SETUP;
         end
         ST_A_SETUP: begin
            rq_in = (prod_ff < HDR_A) ? HDR_A : prod_ff;
            state_in = ST_A_LOOP;
         end
         ST_A_LOOP: begin
            if (cv_ff && (n_ff < NW'(WALK_LIMIT))) begin
               fu_start = 1'b1;
               fu_cmd.op = FU_READ;
               fu_cmd.addr = FA_W'(cur_ff);
               ret_in = ST_A_SIZE;
               state_in = ST_WAIT;
            end else if (!found_ff) begin
               state_in = ST_RESP;
            end else begin
               fu_start = 1'b1;
               fu_cmd.op = FU_READ;
               fu_cmd.addr = FA_W'(tgt_ff) + HALF_A;
               ret_in = ST_A_TLINK;
               state_in = ST_WAIT;
            end
         end
         ST_A_SIZE: begin
            if (take) begin
               found_in = 1'b1;
               tgt_in = cur_ff;
               tsize_in = s_f;
               tprev_in = prev_ff;
               tpv_in = pv_ff;
            end
            fu_start = 1'b1;
            fu_cmd.op = FU_READ;
            fu_cmd.addr = FA_W'(cur_ff) + HALF_A;
            ret_in = ST_A_NEXT;
            state_in = ST_WAIT;
         end
         ST_A_NEXT: begin
            prev_in = cur_ff;
            pv_in = 1'b1;
            cv_in = s_f[FIELD_W-1];
            cur_in = s_f[OFF_W-1:0];
            n_in = n_ff + NW'(1);
            state_in = ST_A_LOOP;
         end
         ST_A_TLINK: begin
            nx_in = s_f;
            if (diff_c < HDR_F) begin
               // Absorb the small remainder
               grant_in = tsize_ff;
               repl_in = s_f;
               state_in = ST_A_SETLINK;
            end else begin
               // Split: shrink the target, then lay a header after the grant
               grant_in = rq_ff[FIELD_W-1:0];
               diff_in = diff_c;
               nb_in = FA_W'(tgt_ff) + HDR_A + rq_ff;
               repl_in = {1'b1, nb_in[OFF_W-1:0]};
               fu_start = 1'b1;
               fu_cmd.op = FU_WRITE;
               fu_cmd.addr = FA_W'(tgt_ff);
               fu_cmd.data = rq_ff[FIELD_W-1:0];
               ret_in = ST_A_SPLIT2;
               state_in = ST_WAIT;
            end
         end
         ST_A_SPLIT2: begin
            fu_start = 1'b1;
            fu_cmd.op = FU_WRITE;
            fu_cmd.addr = nb_ff;
            fu_cmd.data = diff_ff - HDR_F;
            ret_in = ST_A_SPLIT3;
            state_in = ST_WAIT;
         end
         ST_A_SPLIT3: begin
            fu_start = 1'b1;
            fu_cmd.op = FU_WRITE;
            fu_cmd.addr = nb_ff + HALF_A;
            fu_cmd.data = nx_ff;
            ret_in = ST_A_SETLINK;
            state_in = ST_WAIT;
         end
         ST_A_SETLINK: begin
            if (tpv_ff) begin
               fu_start = 1'b1;
               fu_cmd.op = FU_WRITE;
               fu_cmd.addr = FA_W'(tprev_ff) + HALF_A;
               fu_cmd.data = repl_ff;
               ret_in = ST_A_CLRLINK;
               state_in = ST_WAIT;
            end else begin
               head_in = repl_ff[OFF_W-1:0];
               hv_in = repl_ff[FIELD_W-1];
               state_in = ST_A_CLRLINK;
            end
         end
         ST_A_CLRLINK: begin
            rs_in = STS_DONE;
            roff_in = 16'(FA_W'(tgt_ff) + HDR_A);
            rgrant_in = grant_ff[16:0];
            fu_start = 1'b1;
            fu_cmd.op = FU_WRITE;
            fu_cmd.addr = FA_W'(tgt_ff) + HALF_A;
            fu_cmd.data = '0;
            ret_in = ST_RESP;
            state_in = ST_WAIT;
         end

         // ---------------- free ----------------
         ST_F_CHK: begin
            rs_in = STS_IGNORED;
            roff_in = '0;
            rgrant_in = '0;
            if (!fv_ff || (FIELD_W'(off_ff) < HDR_F) || (FIELD_W'(off_ff) > eff_f)) begin
               state_in = ST_RESP;
            end else begin
               tgt_in = OFF_W'(off_ff) - OFF_W'(HEADER_BYTES);
               cur_in = head_ff;
               cv_in = hv_ff;
               pv_in = 1'b0;
               prev_in = '0;
               n_in = '0;
               state_in = ST_F_LOOP;
            end
         end
         ST_F_LOOP: begin
            if (cv_ff && (cur_ff < tgt_ff) && (n_ff < NW'(WALK_LIMIT))) begin
               fu_start = 1'b1;
               fu_cmd.op = FU_READ;
               fu_cmd.addr = FA_W'(cur_ff) + HALF_A;
               ret_in = ST_F_NEXT;
               state_in = ST_WAIT;
            end else if (cv_ff && (cur_ff == tgt_ff)) begin
               // Already free at that address
               state_in = ST_RESP;
            end else begin
               fu_start = 1'b1;
               fu_cmd.op = FU_READ;
               fu_cmd.addr = FA_W'(tgt_ff);
               ret_in = ST_F_ST;
               state_in = ST_WAIT;
            end
         end
         ST_F_NEXT: begin
            prev_in = cur_ff;
            pv_in = 1'b1;
            cv_in = s_f[FIELD_W-1];
            cur_in = s_f[OFF_W-1:0];
            n_in = n_ff + NW'(1);
            state_in = ST_F_LOOP;
         end
         ST_F_ST: begin
            st_in = s_f;
            rs_in = STS_DONE;
            if (pv_ff) begin
               fu_start = 1'b1;
               fu_cmd.op = FU_WRITE;
               fu_cmd.addr = FA_W'(prev_ff) + HALF_A;
               fu_cmd.data = {1'b1, tgt_ff};
               ret_in = ST_F_TLINK;
               state_in = ST_WAIT;
            end else begin
               head_in = tgt_ff;
               hv_in = 1'b1;
               state_in = ST_F_TLINK;
            end
         end
         ST_F_TLINK: begin
            fu_start = 1'b1;
            fu_cmd.op = FU_WRITE;
            fu_cmd.addr = FA_W'(tgt_ff) + HALF_A;
            fu_cmd.data = cv_ff ? {1'b1, cur_ff} : '0;
            ret_in = ST_F_NCHK;
            state_in = ST_WAIT;
         end
         ST_F_NCHK: begin
            // Merge with the following free block when it touches
            if (cv_ff && ((FA_W'(tgt_ff) + HDR_A + FA_W'(st_ff)) == FA_W'(cur_ff))) begin
               fu_start = 1'b1;
               fu_cmd.op = FU_READ;
               fu_cmd.addr = FA_W'(cur_ff);
               ret_in = ST_F_NSZ;
               state_in = ST_WAIT;
            end else begin
               state_in = ST_F_PCHK;
            end
         end
         ST_F_NSZ: begin
            st_in = sum_c;
            fu_start = 1'b1;
            fu_cmd.op = FU_WRITE;
            fu_cmd.addr = FA_W'(tgt_ff);
            fu_cmd.data = sum_c;
            ret_in = ST_F_NLNK;
            state_in = ST_WAIT;
         end
         ST_F_NLNK: begin
            fu_start = 1'b1;
            fu_cmd.op = FU_READ;
            fu_cmd.addr = FA_W'(cur_ff) + HALF_A;
            ret_in = ST_F_NWR;
            state_in = ST_WAIT;
         end
         ST_F_NWR: begin
            fu_start = 1'b1;
            fu_cmd.op = FU_WRITE;
            fu_cmd.addr = FA_W'(tgt_ff) + HALF_A;
            fu_cmd.data = s_f;
            ret_in = ST_F_PCHK;
            state_in = ST_WAIT;
         end
         ST_F_PCHK: begin
            if (pv_ff) begin
               fu_start = 1'b1;
               fu_cmd.op = FU_READ;
               fu_cmd.addr = FA_W'(prev_ff);
               ret_in = ST_F_PSZ;
               state_in = ST_WAIT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_F_PSZ: begin
            // Merge into the preceding free block when it touches
            if ((FA_W'(prev_ff) + HDR_A + FA_W'(s_f)) == FA_W'(tgt_ff)) begin
               fu_start = 1'b1;
               fu_cmd.op = FU_WRITE;
               fu_cmd.addr = FA_W'(prev_ff);
               fu_cmd.data = sum_c;
               ret_in = ST_F_PLNK;
               state_in = ST_WAIT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_F_PLNK: begin
            fu_start = 1'b1;
            fu_cmd.op = FU_READ;
            fu_cmd.addr = FA_W'(tgt_ff) + HALF_A;
            ret_in = ST_F_PWR;
            state_in = ST_WAIT;
         end
         ST_F_PWR: begin
            fu_start = 1'b1;
            fu_cmd.op = FU_WRITE;
            fu_cmd.addr = FA_W'(prev_ff) + HALF_A;
            fu_cmd.data = s_f;
            ret_in = ST_RESP;
            state_in = ST_WAIT;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Field unit is only started when idle
   `SFLA_ASSERT_IMP(a_fu_start_idle, clock, reset, fu_start, !fu_sts.busy, "field unit busy at start")
   // Field unit completion is only seen while the sequencer waits for it
   `SFLA_ASSERT_IMP(a_fu_done_wait, clock, reset, fu_sts.done, state_ff == ST_WAIT, "stray field done")
   // One request at a time
   `SFLA_ASSERT_NXT(a_one_req, clock, reset, req_tvalid && req_tready, !req_tready, "ready after accept")
   // No status code beyond the defined ones
   `SFLA_ASSERT_IMP(a_rsp_status, clock, reset, rsp_tvalid, rsp_tuser != 2'd3, "bad status code")

endmodule
